### hw/rtl/zvc_pkg.sv
// Shared types, codes and helpers for the zigzag/LEB128 varint codec.
// No dependencies; imported by every module of the codec.
package zvc_pkg;

   localparam int VALUE_W     = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic       REQ_ENCODE  = 1'b0;
   localparam logic       REQ_DECODE  = 1'b1;
   localparam logic       KIND_BYTE   = 1'b0;
   localparam logic       KIND_VALUE  = 1'b1;

   localparam logic       CSR_WIDE_MODE   = 1'b0;
   localparam logic       CSR_ZIGZAG_MODE = 1'b1;

   localparam logic [3:0] DEC_LIMIT_NARROW = 4'd5;
   localparam logic [3:0] DEC_LIMIT_WIDE   = 4'd10;
   localparam logic [3:0] ENC_LAST_INDEX   = 4'd9;

   typedef struct packed {
      logic                kind;
      logic [VALUE_W-1:0]  value;
      logic                forced;
   } job_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EMIT
   } back_state_type;

   function automatic logic [VALUE_W-1:0] width_mask(input logic wide);
      width_mask = wide ? {VALUE_W{1'b1}} : {{(VALUE_W/2){1'b0}}, {(VALUE_W/2){1'b1}}};
   endfunction

endpackage

### hw/rtl/zvc_front.sv
// Front end: takes requests, runs the decode accumulator and maps encode values.
// Pushes one job per encode request or completed decode. Depends on zvc_pkg.
module zvc_front
   import zvc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               req_type,
   input  logic [63:0]        req_value_in,
   input  logic [7:0]         req_byte_in,
   input  logic               wide_mode,
   input  logic               zigzag_mode,
   output logic               job_push,
   output job_type            job
);

   logic [63:0] accum_ff, accum_in;
   logic [3:0]  count_ff, count_in;

   logic [63:0] mask;
   logic [63:0] enc_raw;
   logic        enc_sign;
   logic [63:0] enc_val;
   logic [6:0]  shamt;
   logic [63:0] part;
   logic [63:0] accum_nx;
   logic [3:0]  count_nx;
   logic [3:0]  limit;
   logic        cont;
   logic        dec_done;
   logic [63:0] dec_val;

   always_comb begin
      mask     = width_mask(wide_mode);
      enc_raw  = req_value_in & mask;
      enc_sign = wide_mode ? enc_raw[63] : enc_raw[31];
      enc_val  = zigzag_mode ? (((enc_raw << 1) ^ {64{enc_sign}}) & mask) : enc_raw;

      shamt    = {count_ff, 3'b000} - {3'b000, count_ff};
      part     = shamt[6] ? 64'd0 : ({57'd0, req_byte_in[6:0]} << shamt[5:0]);
      accum_nx = (accum_ff | part) & mask;
      count_nx = count_ff + 4'd1;
      limit    = wide_mode ? DEC_LIMIT_WIDE : DEC_LIMIT_NARROW;
      cont     = req_byte_in[7];
      dec_done = !cont || (count_nx >= limit);
      dec_val  = zigzag_mode ? (((accum_nx >> 1) ^ {64{accum_nx[0]}}) & mask) : accum_nx;
   end

   always_comb begin
      accum_in   = accum_ff;
      count_in   = count_ff;
      job_push   = 1'b0;
      job.kind   = KIND_BYTE;
      job.value  = enc_val;
      job.forced = 1'b0;
      if (accept) begin
         if (req_type == REQ_ENCODE) begin
            job_push = 1'b1;
         end else begin
            if (dec_done) begin
               job_push   = 1'b1;
               job.kind   = KIND_VALUE;
               job.value  = dec_val;
               job.forced = cont;
               accum_in   = 64'd0;
               count_in   = 4'd0;
            end else begin
               accum_in = accum_nx;
               count_in = count_nx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= 64'd0;
         count_ff <= 4'd0;
      end else begin
         accum_ff <= accum_in;
         count_ff <= count_in;
      end
   end

endmodule

### hw/rtl/zvc_queue.sv
// Short job queue between front end and back end.
// Register-based, one write and one head read per cycle. Depends on zvc_pkg.
module zvc_queue
   import zvc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  job_type  wr_job,
   input  logic     rd_en,
   output logic     q_full,
   output logic     q_valid,
   output job_type  rd_job
);

   job_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wptr_ff, wptr_in;
   logic [QUEUE_AW-1:0]   rptr_ff, rptr_in;
   logic [QUEUE_AW:0]     fill_ff, fill_in;

   always_comb begin
      q_full  = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
      q_valid = (fill_ff != '0);
      rd_job  = slot_ff[rptr_ff];
      wptr_in = wr_en ? wptr_ff + QUEUE_AW'(1) : wptr_ff;
      rptr_in = rd_en ? rptr_ff + QUEUE_AW'(1) : rptr_ff;
      fill_in = fill_ff;
      if (wr_en && !rd_en) begin
         fill_in = fill_ff + (QUEUE_AW+1)'(1);
      end else if (!wr_en && rd_en) begin
         fill_in = fill_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

### hw/rtl/zvc_back.sv
// Back end: turns jobs into responses, one encode byte per cycle while
// no response is held. Holds the response register. Depends on zvc_pkg.
module zvc_back
   import zvc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   input  job_type      job,
   output logic         job_pop,
   input  logic         pop,
   output logic         empty,
   output logic         rsp_result_kind,
   output logic [7:0]   rsp_byte_out,
   output logic [63:0]  rsp_value_out,
   output logic         rsp_last,
   output logic         rsp_forced_end
);

   back_state_type state_ff, state_in;
   logic [56:0]    val_ff, val_in;
   logic [3:0]     cnt_ff, cnt_in;
   logic           valid_ff, valid_in;
   logic           kind_ff, kind_in;
   logic [7:0]     byte_ff, byte_in;
   logic [63:0]    value_ff, value_in;
   logic           last_ff, last_in;
   logic           forced_ff, forced_in;

   logic           slot_free;
   logic           emit_final;
   logic           job_multi;
   logic           load;

   assign slot_free  = !valid_ff || pop;
   assign emit_final = (val_ff[56:7] == '0) || (cnt_ff == ENC_LAST_INDEX);
   assign job_multi  = (job.value[63:7] != '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (job_valid && slot_free && job.kind == KIND_BYTE && job_multi) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (slot_free && emit_final) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      job_pop   = 1'b0;
      load      = 1'b0;
      val_in    = val_ff;
      cnt_in    = cnt_ff;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      value_in  = value_ff;
      last_in   = last_ff;
      forced_in = forced_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (job_valid && slot_free) begin
               job_pop = 1'b1;
               load    = 1'b1;
               if (job.kind == KIND_VALUE) begin
                  kind_in   = KIND_VALUE;
                  byte_in   = 8'd0;
                  value_in  = job.value;
                  last_in   = 1'b1;
                  forced_in = job.forced;
               end else begin
                  kind_in   = KIND_BYTE;
                  byte_in   = {job_multi, job.value[6:0]};
                  value_in  = 64'd0;
                  last_in   = !job_multi;
                  forced_in = 1'b0;
                  val_in    = job.value[63:7];
                  cnt_in    = 4'd1;
               end
            end
         end
         BACK_EMIT: begin
            if (slot_free) begin
               load      = 1'b1;
               kind_in   = KIND_BYTE;
               byte_in   = {!emit_final, val_ff[6:0]};
               value_in  = 64'd0;
               last_in   = emit_final;
               forced_in = 1'b0;
               val_in    = {7'd0, val_ff[56:7]};
               cnt_in    = cnt_ff + 4'd1;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
      valid_in = load ? 1'b1 : (pop ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         valid_ff <= 1'b0;
         cnt_ff   <= 4'd0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
      forced_ff <= forced_in;
   end

   assign empty           = !valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_byte_out    = byte_ff;
   assign rsp_value_out   = value_ff;
   assign rsp_last        = last_ff;
   assign rsp_forced_end  = forced_ff;

endmodule

### hw/rtl/zigzag_varint_codec_core.sv
// Top level of the zigzag/LEB128 varint codec: control registers and wiring.
// Depends on zvc_pkg, zvc_front, zvc_queue and zvc_back.
//
//   channel   | handshake              | payload
//   ----------+------------------------+------------------------------------------
//   request   | push / full            | req_type, req_value_in, req_byte_in
//   response  | empty / pop            | rsp_result_kind, rsp_byte_out,
//             |                        | rsp_value_out, rsp_last, rsp_forced_end
//   registers | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// A request is taken every cycle while the 4-entry job queue has room.
// A decode byte is folded in on the cycle it is taken; a finished value leaves
// through the job queue and then the response register.
// An encode request yields 1 to 10 bytes from the back-end serialiser, one per
// cycle while responses are popped; the front end keeps taking requests until
// the queue fills. Synchronous reset clears the decode state, queue, serialiser
// and modes (wide on, zigzag off). A held response stalls the back end directly.
module zigzag_varint_codec_core
   import zvc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  logic         req_type,
   input  logic [63:0]  req_value_in,
   input  logic [7:0]   req_byte_in,
   output logic         empty,
   input  logic         pop,
   output logic         rsp_result_kind,
   output logic [7:0]   rsp_byte_out,
   output logic [63:0]  rsp_value_out,
   output logic         rsp_last,
   output logic         rsp_forced_end,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic    wide_ff, wide_in;
   logic    zigzag_ff, zigzag_in;
   logic    csr_wr;
   logic    accept;
   logic    job_push;
   job_type front_job;
   logic    q_full;
   logic    q_valid;
   logic    q_pop;
   job_type head_job;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      wide_in   = wide_ff;
      zigzag_in = zigzag_ff;
      if (csr_wr) begin
         case (paddr[2])
            CSR_WIDE_MODE:   wide_in   = pwdata[0];
            CSR_ZIGZAG_MODE: zigzag_in = pwdata[0];
            default:         wide_in   = wide_ff;
         endcase
      end
      case (paddr[2])
         CSR_WIDE_MODE:   prdata = {31'd0, wide_ff};
         CSR_ZIGZAG_MODE: prdata = {31'd0, zigzag_ff};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff   <= 1'b1;
         zigzag_ff <= 1'b0;
      end else begin
         wide_ff   <= wide_in;
         zigzag_ff <= zigzag_in;
      end
   end

   assign full   = q_full;
   assign accept = push && !q_full;

   zvc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_type     (req_type),
      .req_value_in (req_value_in),
      .req_byte_in  (req_byte_in),
      .wide_mode    (wide_ff),
      .zigzag_mode  (zigzag_ff),
      .job_push     (job_push),
      .job          (front_job)
   );

   zvc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_job  (front_job),
      .rd_en   (q_pop),
      .q_full  (q_full),
      .q_valid (q_valid),
      .rd_job  (head_job)
   );

   zvc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (q_valid),
      .job             (head_job),
      .job_pop         (q_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_result_kind (rsp_result_kind),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_value_out   (rsp_value_out),
      .rsp_last        (rsp_last),
      .rsp_forced_end  (rsp_forced_end)
   );

endmodule

### tb/tb.sv
// Testbench for zigzag_varint_codec_core: LEB128 encode and decode requests with
// random push/pop pacing, checked against a built-in predictor and scoreboard.
// Depends on zvc_pkg and the codec RTL only.
module tb
   import zvc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 20;

   typedef struct packed {
      logic        kind;
      logic [7:0]  byte_out;
      logic [63:0] value_out;
      logic        last;
      logic        forced;
   } varint_result_type;

   class varint_scoreboard;
      logic              wide_mode;
      logic              zigzag_mode;
      logic [63:0]       dec_accum;
      logic [3:0]        dec_count;
      varint_result_type pending[$];
      int                errors;
      int                responses;

      function new();
         wide_mode   = 1'b1;
         zigzag_mode = 1'b0;
         dec_accum   = '0;
         dec_count   = '0;
         errors      = 0;
         responses   = 0;
      endfunction

      function void set_mode(logic idx, logic val);
         if (idx == CSR_WIDE_MODE)
            wide_mode = val;
         else
            zigzag_mode = val;
      endfunction

      function void expect_result(logic k, logic [7:0] b, logic [63:0] v, logic l, logic f);
         varint_result_type r;
         r.kind      = k;
         r.byte_out  = b;
         r.value_out = v;
         r.last      = l;
         r.forced    = f;
         pending     = {pending, r};
      endfunction

      function void note_request(logic t, logic [63:0] v_in, logic [7:0] b_in);
         logic [63:0] mask;
         logic [63:0] code;
         logic [63:0] group;
         int          top;
         int          n;
         int          shift;
         mask = wide_mode ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
         top  = wide_mode ? 63 : 31;
         if (t == REQ_ENCODE) begin
            code = v_in & mask;
            if (zigzag_mode)
               code = ((code << 1) ^ {64{code[top]}}) & mask;
            n = 0;
            while (code >= 64'd128 && n < 9) begin
               expect_result(KIND_BYTE, {1'b1, code[6:0]}, '0, 1'b0, 1'b0);
               code = code >> 7;
               n++;
            end
            expect_result(KIND_BYTE, code[7:0], '0, 1'b1, 1'b0);
         end else begin
            shift = 7 * int'(dec_count);
            if (shift < 64) begin
               group = {57'd0, b_in[6:0]};
               dec_accum = dec_accum | (group << shift);
            end
            dec_accum = dec_accum & mask;
            dec_count = dec_count + 4'd1;
            if (b_in[7] && dec_count < (wide_mode ? DEC_LIMIT_WIDE : DEC_LIMIT_NARROW))
               return;
            code = dec_accum & mask;
            if (zigzag_mode)
               code = ((code >> 1) ^ {64{code[0]}}) & mask;
            expect_result(KIND_VALUE, 8'd0, code, 1'b1, b_in[7]);
            dec_accum = '0;
            dec_count = '0;
         end
      endfunction

      task report_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
         $display("response %0d: %s got %h expected %h", responses, what, got_v, want_v);
         errors++;
      endtask

      task check_response(varint_result_type got);
         varint_result_type want;
         responses++;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response, value", got.value_out, '0);
            return;
         end
         want = pending.pop_front();
         if (got.kind !== want.kind)
            report_mismatch("result_kind", 64'(got.kind), 64'(want.kind));
         if (got.byte_out !== want.byte_out)
            report_mismatch("byte_out", 64'(got.byte_out), 64'(want.byte_out));
         if (got.value_out !== want.value_out)
            report_mismatch("value_out", got.value_out, want.value_out);
         if (got.last !== want.last)
            report_mismatch("last", 64'(got.last), 64'(want.last));
         if (got.forced !== want.forced)
            report_mismatch("forced_end", 64'(got.forced), 64'(want.forced));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic        req_type;
   logic [63:0] req_value_in;
   logic [7:0]  req_byte_in;
   logic        empty;
   logic        pop;
   logic        rsp_result_kind;
   logic [7:0]  rsp_byte_out;
   logic [63:0] rsp_value_out;
   logic        rsp_last;
   logic        rsp_forced_end;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   varint_scoreboard  codec_sb;
   varint_result_type seen;
   int                burst_left;
   int                cycle_count;
   logic [31:0]       stall_pat;
   logic [4:0]        stall_idx;

   zigzag_varint_codec_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_value_in    (req_value_in),
      .req_byte_in     (req_byte_in),
      .empty           (empty),
      .pop             (pop),
      .rsp_result_kind (rsp_result_kind),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_value_out   (rsp_value_out),
      .rsp_last        (rsp_last),
      .rsp_forced_end  (rsp_forced_end),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // receiver back-pressure: a fresh 32-bit pop pattern of random density
   always @(negedge clock) begin
      if (stall_idx == 5'd0) begin
         case ($urandom_range(0, 3))
            0: begin
               stall_pat = '1;
            end
            1: begin
               stall_pat = $urandom;
            end
            2: begin
               stall_pat = $urandom | $urandom;
            end
            default: begin
               stall_pat = $urandom & $urandom & $urandom;
            end
         endcase
      end
      pop <= reset ? 1'b0 : stall_pat[stall_idx];
      stall_idx = stall_idx + 5'd1;
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         seen.kind      = rsp_result_kind;
         seen.byte_out  = rsp_byte_out;
         seen.value_out = rsp_value_out;
         seen.last      = rsp_last;
         seen.forced    = rsp_forced_end;
         codec_sb.check_response(seen);
      end
   end

   task automatic send_request(input logic t, input logic [63:0] v, input logic [7:0] b);
      if (burst_left == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_type     <= t;
      req_value_in <= v;
      req_byte_in  <= b;
      push         <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      codec_sb.note_request(t, v, b);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic encode_value(input logic [63:0] v);
      send_request(REQ_ENCODE, v, 8'($urandom));
   endtask

   task automatic decode_byte(input logic [7:0] b);
      send_request(REQ_DECODE, {$urandom, $urandom}, b);
   endtask

   task automatic wait_idle();
      push       <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (codec_sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      codec_sb.set_mode(idx, data[0]);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_modes(input logic wide, input logic zz);
      wait_idle();
      write_csr(CSR_WIDE_MODE,
                {$urandom_range(0, 1) ? $urandom : 32'd0} & ~32'd1 | {31'd0, wide});
      write_csr(CSR_ZIGZAG_MODE, {31'd0, zz});
   endtask

   task automatic run_random(input int n_items);
      int          done;
      int          len;
      int          limit;
      int          nbits;
      logic [63:0] v;
      logic [7:0]  b;
      done = 0;
      while (done < n_items) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               nbits = $urandom_range(0, 64);
               v = {$urandom, $urandom};
               if (nbits < 64)
                  v = v & ((64'd1 << nbits) - 64'd1);
               encode_value(v);
               done++;
            end
            9: begin
               decode_byte(8'($urandom));
               done++;
            end
            default: begin
               // varint, now and then run to the byte limit with a random last continuation bit
               limit = codec_sb.wide_mode ? 10 : 5;
               len = ($urandom_range(0, 3) == 0) ? limit : $urandom_range(1, 3);
               for (int i = 0; i < len; i++) begin
                  b = 8'($urandom);
                  b[7] = (i != len - 1) || (len == limit && $urandom_range(0, 1));
                  decode_byte(b);
                  done++;
               end
            end
         endcase
      end
   endtask

   initial begin
      codec_sb     = new();
      cycle_count  = 0;
      burst_left   = 0;
      stall_idx    = '0;
      stall_pat    = '1;
      reset        = 1'b1;
      push         = 1'b0;
      pop          = 1'b0;
      req_type     = REQ_ENCODE;
      req_value_in = '0;
      req_byte_in  = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset modes: 64-bit, no zigzag
      encode_value(64'd0);
      encode_value(64'h7F);
      encode_value(64'h80);
      encode_value({64{1'b1}});
      encode_value(64'h8000_0000_0000_0000);
      decode_byte(8'h00);
      decode_byte(8'hFF);
      decode_byte(8'h7F);
      // encode slipped into a partial decode
      decode_byte(8'h81);
      encode_value(64'h3FFF);
      decode_byte(8'h01);
      repeat (10) decode_byte(8'hFF);
      // partial decode carried across a mode change
      decode_byte(8'h85);

      set_modes(1'b0, 1'b1);
      decode_byte(8'h03);
      encode_value(64'h0000_0000_8000_0000);
      encode_value(64'hFFFF_FFFF_7FFF_FFFF);
      repeat (5) decode_byte(8'h80);
      run_random(12);

      set_modes(1'b1, 1'b1);
      run_random(12);
      encode_value(64'h8000_0000_0000_0000);
      repeat (7) decode_byte(8'hAA);

      // count already past the narrow limit
      set_modes(1'b0, 1'b0);
      decode_byte(8'h01);
      run_random(12);

      set_modes(1'b1, 1'b0);
      run_random(12);

      repeat (2) begin
         set_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         run_random(10);
      end

      wait_idle();
      if (codec_sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### zigzag_varint_codec_core.f
hw/rtl/zvc_pkg.sv
hw/rtl/zvc_front.sv
hw/rtl/zvc_queue.sv
hw/rtl/zvc_back.sv
hw/rtl/zigzag_varint_codec_core.sv
tb/tb.sv
